>>> rtl/core/prfm_pkg.sv
// ----------------------------------------------------------------------------
// prfm_pkg
// Shared types and constants for the first-match policy rule engine.
// ----------------------------------------------------------------------------
`default_nettype none

package prfm_pkg;

   localparam int MAX_RULES_DEF = 64;

   localparam int DOMAIN_W   = 16;
   localparam int ACT_W      = 8;
   localparam int TRUST_W    = 16;
   localparam int CAPS_W     = 32;
   localparam int RULE_IDX_W = 6;   // width of the reported rule index
   localparam int BIAS_W     = 7;   // holds -50..+50
   localparam int NEED_MIN_W = 7;   // holds 0..100

   localparam int BIAS_LIM   = 50;
   localparam int TRUST_CEIL = 100;

   typedef enum logic [1:0] {
      VERDICT_DENY     = 2'd0,
      VERDICT_ALLOW    = 2'd1,
      VERDICT_ESCALATE = 2'd2
   } verdict_type;

   typedef enum logic {
      OP_ADD  = 1'b0,
      OP_EVAL = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_JUDGE,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                any;
      logic [DOMAIN_W-1:0] domain;
      logic [ACT_W-1:0]    act;
   } key_type;

   typedef struct packed {
      logic signed [TRUST_W-1:0] trust_floor;
      logic [CAPS_W-1:0]         caps;
   } need_type;

   typedef struct packed {
      key_type  key;
      need_type need;
   } rule_type;

endpackage

`default_nettype wire

>>> rtl/core/prfm_if.sv
// ----------------------------------------------------------------------------
// prfm request / response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
`default_nettype none

interface prfm_req_if;
   import prfm_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       action;
   logic                       rule_any_domain;
   logic [DOMAIN_W-1:0]        rule_domain;
   logic [ACT_W-1:0]           action_code;
   logic signed [TRUST_W-1:0]  rule_min_trust;
   logic [CAPS_W-1:0]          rule_caps;
   logic                       subject_blocked;
   logic [DOMAIN_W-1:0]        subject_domain;
   logic signed [TRUST_W-1:0]  subject_score;
   logic signed [TRUST_W-1:0]  subject_bias;
   logic [CAPS_W-1:0]          subject_caps;

   modport source (
      output valid, action, rule_any_domain, rule_domain, action_code,
             rule_min_trust, rule_caps, subject_blocked, subject_domain,
             subject_score, subject_bias, subject_caps,
      input  ready
   );

   modport sink (
      input  valid, action, rule_any_domain, rule_domain, action_code,
             rule_min_trust, rule_caps, subject_blocked, subject_domain,
             subject_score, subject_bias, subject_caps,
      output ready
   );
endinterface

interface prfm_rsp_if;
   import prfm_pkg::*;

   logic                  valid;
   logic                  ready;
   verdict_type           verdict;
   logic                  matched;
   logic [RULE_IDX_W-1:0] rule_index;
   logic                  table_full;

   modport source (
      output valid, verdict, matched, rule_index, table_full,
      input  ready
   );

   modport sink (
      input  valid, verdict, matched, rule_index, table_full,
      output ready
   );
endinterface

`default_nettype wire

>>> rtl/core/policy_rule_first_match_unit.sv
// ----------------------------------------------------------------------------
// policy_rule_first_match_unit
// Append-only rule table with an in-order first-match policy scan.
// ----------------------------------------------------------------------------
// Add request, or evaluate of a blocked subject: IDLE goes straight to EMIT, and the
//   response register loads from EMIT once the response slot is free.
// Evaluate: one rule read per cycle from the table memory; a match at index k
//   goes SCAN, JUDGE, EMIT and reports k; no match over n rules goes from SCAN to EMIT.
// One request at a time; the next is taken the cycle after the response loads.
// Reset (synchronous, active high) empties the table; entries are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module policy_rule_first_match_unit #(
   parameter int MAX_RULES = prfm_pkg::MAX_RULES_DEF
) (
   input  wire logic   clock,
   input  wire logic   reset,
   prfm_req_if.sink    req_chan,
   prfm_rsp_if.source  rsp_chan
);
   import prfm_pkg::*;

   // Count must hold MAX_RULES itself; index addresses the table.
   localparam int CNT_W = $clog2(MAX_RULES + 1);
   localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   state_type                 state_ff,       state_in;
   logic [CNT_W-1:0]          count_ff,       count_in;
   logic [CNT_W-1:0]          ptr_ff,         ptr_in;       // next rule to read
   logic                      pend_ff,        pend_in;      // read data valid now
   logic [IDX_W-1:0]          pend_idx_ff,    pend_idx_in;  // index of that read

   // request fields latched for the scan
   logic [DOMAIN_W-1:0]       dom_ff,         dom_in;
   logic [ACT_W-1:0]          act_ff,         act_in;
   logic signed [TRUST_W-1:0] score_ff,       score_in;
   logic signed [BIAS_W-1:0]  bias_ff,        bias_in;
   logic [CAPS_W-1:0]         have_ff,        have_in;

   // matched rule
   need_type                  hit_need_ff,    hit_need_in;
   logic [IDX_W-1:0]          hit_idx_ff,     hit_idx_in;

   // pending result
   verdict_type               res_verdict_ff, res_verdict_in;
   logic                      res_matched_ff, res_matched_in;
   logic [RULE_IDX_W-1:0]     res_idx_ff,     res_idx_in;
   logic                      res_full_ff,    res_full_in;

   // response output register
   logic                      rsp_valid_ff,   rsp_valid_in;
   verdict_type               rsp_verdict_ff, rsp_verdict_in;
   logic                      rsp_matched_ff, rsp_matched_in;
   logic [RULE_IDX_W-1:0]     rsp_idx_ff,     rsp_idx_in;
   logic                      rsp_full_ff,    rsp_full_in;

   // ------------------------------------------------------------------
   // Control wires
   // ------------------------------------------------------------------
   logic        req_fire;
   logic        is_add;
   logic        room;       // table not yet full
   logic        more;       // rules left to read
   logic        rd_issue;
   logic        hit;
   logic        slot_free;  // response register can take a new response
   logic        wr_en;
   rule_type    wr_rule;
   rule_type    rd_rule;
   verdict_type judge_verdict;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign is_add    = (req_chan.action == OP_ADD);
   assign room      = (count_ff < CNT_W'(MAX_RULES));
   assign more      = (ptr_ff < count_ff);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   // First match: domain (or wildcard) and action on the word read last cycle.
   assign hit = (state_ff == ST_SCAN) && pend_ff
             && (rd_rule.key.any || (rd_rule.key.domain == dom_ff))
             && (rd_rule.key.act == act_ff);

   assign wr_rule.key.any          = req_chan.rule_any_domain;
   assign wr_rule.key.domain       = req_chan.rule_domain;
   assign wr_rule.key.act          = req_chan.action_code;
   assign wr_rule.need.trust_floor = req_chan.rule_min_trust;
   assign wr_rule.need.caps        = req_chan.rule_caps;

   // ------------------------------------------------------------------
   // Rule table. Writes happen only on add acceptance in IDLE and reads
   // only during SCAN, so the two ports never touch the same entry in
   // overlapping cycles.
   // ------------------------------------------------------------------
   prfm_rule_mem #(
      .DEPTH (MAX_RULES),
      .IDX_W (IDX_W)
   ) u_rule_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_rule (wr_rule),
      .rd_en   (rd_issue),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_rule (rd_rule)
   );

   prfm_judge u_judge (
      .need    (hit_need_ff),
      .bias    (bias_ff),
      .score   (score_ff),
      .have    (have_ff),
      .verdict (judge_verdict)
   );

   // ------------------------------------------------------------------
   // Next state
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (is_add || req_chan.subject_blocked) begin
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            priority if (hit) begin
               state_in = ST_JUDGE;
            end else if (!pend_ff && !more) begin
               state_in = ST_EMIT;   // ran off the end: no match
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_JUDGE: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Outputs and datapath
   // ------------------------------------------------------------------
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign rd_issue       = (state_ff == ST_SCAN) && more;
   assign wr_en          = req_fire && is_add && room;

   always_comb begin
      count_in       = count_ff;
      ptr_in         = ptr_ff;
      pend_in        = 1'b0;
      pend_idx_in    = ptr_ff[IDX_W-1:0];
      dom_in         = dom_ff;
      act_in         = act_ff;
      score_in       = score_ff;
      bias_in        = bias_ff;
      have_in        = have_ff;
      hit_need_in    = hit_need_ff;
      hit_idx_in     = hit_idx_ff;
      res_verdict_in = res_verdict_ff;
      res_matched_in = res_matched_ff;
      res_idx_in     = res_idx_ff;
      res_full_in    = res_full_ff;

      unique case (state_ff)
         ST_IDLE: begin
            ptr_in = '0;
            if (req_fire) begin
               dom_in   = req_chan.subject_domain;
               act_in   = req_chan.action_code;
               score_in = req_chan.subject_score;
               have_in  = req_chan.subject_caps;
               // bias clamped to +/-50 once, at acceptance
               priority if (req_chan.subject_bias < $signed(TRUST_W'(-BIAS_LIM))) begin
                  bias_in = BIAS_W'(-BIAS_LIM);
               end else if (req_chan.subject_bias > $signed(TRUST_W'(BIAS_LIM))) begin
                  bias_in = BIAS_W'(BIAS_LIM);
               end else begin
                  bias_in = req_chan.subject_bias[BIAS_W-1:0];
               end
               // default response: deny, no match
               res_verdict_in = VERDICT_DENY;
               res_matched_in = 1'b0;
               res_idx_in     = '0;
               res_full_in    = is_add && !room;
               if (wr_en) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
         ST_SCAN: begin
            if (rd_issue) begin
               ptr_in  = ptr_ff + CNT_W'(1);
               pend_in = 1'b1;
            end
            if (hit) begin
               hit_need_in = rd_rule.need;
               hit_idx_in  = pend_idx_ff;
            end
         end
         ST_JUDGE: begin
            res_verdict_in = judge_verdict;
            res_matched_in = 1'b1;
            res_idx_in     = RULE_IDX_W'(hit_idx_ff);   // index modulo 64
         end
         ST_EMIT: begin
         end
         default: begin
         end
      endcase
   end

   // Response register: loads from EMIT, drains on rsp ready.
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_matched_in = rsp_matched_ff;
      rsp_idx_in     = rsp_idx_ff;
      rsp_full_in    = rsp_full_ff;
      if ((state_ff == ST_EMIT) && slot_free) begin
         rsp_valid_in   = 1'b1;
         rsp_verdict_in = res_verdict_ff;
         rsp_matched_in = res_matched_ff;
         rsp_idx_in     = res_idx_ff;
         rsp_full_in    = res_full_ff;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.verdict    = rsp_verdict_ff;
   assign rsp_chan.matched    = rsp_matched_ff;
   assign rsp_chan.rule_index = rsp_idx_ff;
   assign rsp_chan.table_full = rsp_full_ff;

   // ------------------------------------------------------------------
   // Flops
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         ptr_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ptr_ff       <= ptr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff    <= pend_idx_in;
      dom_ff         <= dom_in;
      act_ff         <= act_in;
      score_ff       <= score_in;
      bias_ff        <= bias_in;
      have_ff        <= have_in;
      hit_need_ff    <= hit_need_in;
      hit_idx_ff     <= hit_idx_in;
      res_verdict_ff <= res_verdict_in;
      res_matched_ff <= res_matched_in;
      res_idx_ff     <= res_idx_in;
      res_full_ff    <= res_full_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_matched_ff <= rsp_matched_in;
      rsp_idx_ff     <= rsp_idx_in;
      rsp_full_ff    <= rsp_full_in;
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_RULES))
      else $error("rule count beyond table depth");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("request accepted but engine stayed idle");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("response loaded outside emit state");

   a_full_is_plain_deny: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff)
         |-> (!rsp_matched_ff && (rsp_verdict_ff == VERDICT_DENY)))
      else $error("table-full response carries a match or non-deny verdict");

endmodule

`default_nettype wire

>>> rtl/core/prfm_rule_mem.sv
// ----------------------------------------------------------------------------
// prfm_rule_mem
// Rule table storage: key and need arrays, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module prfm_rule_mem #(
   parameter int DEPTH = prfm_pkg::MAX_RULES_DEF,
   parameter int IDX_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [IDX_W-1:0]  wr_addr,
   input  wire prfm_pkg::rule_type wr_rule,
   input  wire logic              rd_en,
   input  wire logic [IDX_W-1:0]  rd_addr,
   output      prfm_pkg::rule_type rd_rule
);
   import prfm_pkg::*;

   key_type  key_mem  [DEPTH];
   need_type need_mem [DEPTH];

   key_type  rd_key_ff;
   need_type rd_need_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr]  <= wr_rule.key;
         need_mem[wr_addr] <= wr_rule.need;
      end
      if (rd_en) begin
         rd_key_ff  <= key_mem[rd_addr];
         rd_need_ff <= need_mem[rd_addr];
      end
   end

   assign rd_rule.key  = rd_key_ff;
   assign rd_rule.need = rd_need_ff;

endmodule

`default_nettype wire

>>> rtl/core/prfm_judge.sv
// ----------------------------------------------------------------------------
// prfm_judge
// Verdict for a matched rule: biased trust floor check, then capability check.
// ----------------------------------------------------------------------------
`default_nettype none

module prfm_judge (
   input  wire prfm_pkg::need_type                  need,
   input  wire logic signed [prfm_pkg::BIAS_W-1:0]  bias,
   input  wire logic signed [prfm_pkg::TRUST_W-1:0] score,
   input  wire logic [prfm_pkg::CAPS_W-1:0]         have,
   output      prfm_pkg::verdict_type               verdict
);
   import prfm_pkg::*;

   logic signed [TRUST_W:0]   sum;
   logic [NEED_MIN_W-1:0]     need_min;
   logic                      below;
   logic                      caps_miss;

   always_comb begin
      sum = $signed({need.trust_floor[TRUST_W-1], need.trust_floor})
          + $signed({{(TRUST_W+1-BIAS_W){bias[BIAS_W-1]}}, bias});

      // clamp biased floor into 0..100
      priority if (sum < $signed((TRUST_W+1)'(0))) begin
         need_min = '0;
      end else if (sum > $signed((TRUST_W+1)'(TRUST_CEIL))) begin
         need_min = NEED_MIN_W'(TRUST_CEIL);
      end else begin
         need_min = sum[NEED_MIN_W-1:0];
      end

      below     = score < $signed({{(TRUST_W-NEED_MIN_W){1'b0}}, need_min});
      // an empty mask always passes
      caps_miss = (have & need.caps) != need.caps;

      priority if (below) begin
         verdict = VERDICT_DENY;
      end else if (caps_miss) begin
         verdict = VERDICT_ESCALATE;
      end else begin
         verdict = VERDICT_ALLOW;
      end
   end

endmodule

`default_nettype wire

>>> verif/policy_rule_first_match_unit_tb.sv
// ----------------------------------------------------------------------------
// policy_rule_first_match_unit_tb
// Self-checking bench for the first-match policy engine. A directed pass
// loads a few rules with extreme fields and evaluates them: exact threshold,
// bias clamping, missing capabilities, shadowed rules and blocked subjects.
// Random traffic then fills the table to its limit and keeps probing it,
// adds past the limit included. Every accepted request is scored by a local
// model of the rule table, and each response is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module policy_rule_first_match_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import prfm_pkg::*;

   localparam int TABLE_DEPTH       = MAX_RULES_DEF;
   localparam int CLK_HALF          = 4;
   localparam int RESET_CYCLES      = 12;
   localparam int GAP_MAX           = 14;
   localparam int RANDOM_REQUESTS   = 1010;
   localparam int SEGMENT_LEN       = 100;
   localparam int PRESSURE_REQUESTS = 14;
   localparam int HOLD_CYCLES       = 400;
   // longest scan covers all 64 rules; leave room for a final stall
   localparam int DRAIN_CYCLES      = 120;
   localparam int CYCLE_LIMIT       = 1_000_000;

   // one request as the sender sees it; fields not used by the op carry noise
   typedef struct {
      op_type                    op;
      logic                      any_domain;
      logic [DOMAIN_W-1:0]       rule_domain;
      logic [ACT_W-1:0]          action_code;
      logic signed [TRUST_W-1:0] trust_floor;
      logic [CAPS_W-1:0]         rule_caps;
      logic                      blocked;
      logic [DOMAIN_W-1:0]       subj_domain;
      logic signed [TRUST_W-1:0] score;
      logic signed [TRUST_W-1:0] bias;
      logic [CAPS_W-1:0]         subj_caps;
   } policy_request_type;

   typedef struct {
      verdict_type           verdict;
      logic                  matched;
      logic [RULE_IDX_W-1:0] rule_index;
      logic                  table_full;
   } policy_decision_type;

   logic clock;
   logic reset;

   prfm_req_if req_bus ();
   prfm_rsp_if rsp_bus ();

   policy_rule_first_match_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // shadow copy of the rule table, updated as requests are accepted
   key_type  rule_keys  [TABLE_DEPTH];
   need_type rule_needs [TABLE_DEPTH];
   int       rule_total = 0;

   // decisions waiting for their response, oldest first
   policy_decision_type decision_q [$];

   int error_count = 0;
   int cycle_count = 0;

   // idling knobs: sender gaps, receiver stalls, and the long receiver hold
   bit send_idle = 1'b1;
   bit rsp_idle  = 1'b1;
   bit rsp_hold  = 1'b0;

   initial begin
      clock = 1'b0;
      forever #(CLK_HALF) clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Model of the engine: appends on add, first-match scan on evaluate.
   // ------------------------------------------------------------------------
   function automatic policy_decision_type decide_policy(input policy_request_type r);
      policy_decision_type d;
      int bias_c;
      int need_min;
      d.verdict    = VERDICT_DENY;
      d.matched    = 1'b0;
      d.rule_index = '0;
      d.table_full = 1'b0;
      if (r.op == OP_ADD) begin
         if (rule_total < TABLE_DEPTH) begin
            rule_keys[rule_total].any          = r.any_domain;
            rule_keys[rule_total].domain       = r.rule_domain;
            rule_keys[rule_total].act          = r.action_code;
            rule_needs[rule_total].trust_floor = r.trust_floor;
            rule_needs[rule_total].caps        = r.rule_caps;
            rule_total++;
         end else begin
            // full table: rule dropped, nothing else changes
            d.table_full = 1'b1;
         end
      end else if (!r.blocked) begin
         bias_c = int'($signed(r.bias));
         if (bias_c > BIAS_LIM) bias_c = BIAS_LIM;
         if (bias_c < -BIAS_LIM) bias_c = -BIAS_LIM;
         for (int i = 0; i < rule_total; i++) begin
            if ((rule_keys[i].any || rule_keys[i].domain == r.subj_domain) &&
                rule_keys[i].act == r.action_code) begin
               d.matched    = 1'b1;
               d.rule_index = RULE_IDX_W'(i);
               need_min = int'($signed(rule_needs[i].trust_floor)) + bias_c;
               if (need_min < 0) need_min = 0;
               if (need_min > TRUST_CEIL) need_min = TRUST_CEIL;
               if (int'($signed(r.score)) < need_min)
                  d.verdict = VERDICT_DENY;
               else if (rule_needs[i].caps != '0 &&
                        (r.subj_caps & rule_needs[i].caps) != rule_needs[i].caps)
                  d.verdict = VERDICT_ESCALATE;
               else
                  d.verdict = VERDICT_ALLOW;
               break;
            end
         end
      end
      return d;
   endfunction

   // ------------------------------------------------------------------------
   // Request builders
   // ------------------------------------------------------------------------
   function automatic policy_request_type noise_request();
      policy_request_type r;
      r.op          = op_type'($urandom_range(0, 1));
      r.any_domain  = 1'($urandom_range(0, 1));
      r.rule_domain = DOMAIN_W'($urandom);
      r.action_code = ACT_W'($urandom);
      r.trust_floor = TRUST_W'($urandom);
      r.rule_caps   = $urandom;
      r.blocked     = 1'($urandom_range(0, 1));
      r.subj_domain = DOMAIN_W'($urandom);
      r.score       = TRUST_W'($urandom);
      r.bias        = TRUST_W'($urandom);
      r.subj_caps   = $urandom;
      return r;
   endfunction

   function automatic policy_request_type rule_append_req(
      input logic                      any_domain,
      input logic [DOMAIN_W-1:0]       domain,
      input logic [ACT_W-1:0]          act,
      input logic signed [TRUST_W-1:0] trust_floor,
      input logic [CAPS_W-1:0]         caps);
      policy_request_type r;
      r = noise_request();
      r.op          = OP_ADD;
      r.any_domain  = any_domain;
      r.rule_domain = domain;
      r.action_code = act;
      r.trust_floor = trust_floor;
      r.rule_caps   = caps;
      return r;
   endfunction

   function automatic policy_request_type access_check_req(
      input logic                      blocked,
      input logic [DOMAIN_W-1:0]       domain,
      input logic [ACT_W-1:0]          act,
      input logic signed [TRUST_W-1:0] score,
      input logic signed [TRUST_W-1:0] bias,
      input logic [CAPS_W-1:0]         caps);
      policy_request_type r;
      r = noise_request();
      r.op          = OP_EVAL;
      r.blocked     = blocked;
      r.subj_domain = domain;
      r.action_code = act;
      r.score       = score;
      r.bias        = bias;
      r.subj_caps   = caps;
      return r;
   endfunction

   // small pools so random rules and subjects actually collide
   function automatic logic [DOMAIN_W-1:0] pick_domain();
      logic [DOMAIN_W-1:0] pool [4] = '{16'h0001, 16'h00A5, 16'h8000, 16'hFFFE};
      if ($urandom_range(0, 99) < 80) return pool[$urandom_range(0, 3)];
      return DOMAIN_W'($urandom);
   endfunction

   function automatic logic [ACT_W-1:0] pick_action();
      if ($urandom_range(0, 99) < 80) return ACT_W'($urandom_range(1, 4));
      return ACT_W'($urandom);
   endfunction

   function automatic logic [CAPS_W-1:0] sparse_caps();
      return (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
   endfunction

   function automatic policy_request_type random_request();
      policy_request_type r;
      int roll;
      r    = noise_request();
      roll = $urandom_range(0, 99);
      // adds are common while the table has room, rare once it is full
      if ((rule_total < TABLE_DEPTH) ? (roll < 15) : (roll < 3)) begin
         r.op          = OP_ADD;
         r.any_domain  = ($urandom_range(0, 99) < 15);
         r.rule_domain = pick_domain();
         r.action_code = pick_action();
         if ($urandom_range(0, 99) < 85)
            r.trust_floor = TRUST_W'($urandom_range(0, 200) - 60);
         roll = $urandom_range(0, 99);
         if (roll < 40)      r.rule_caps = '0;
         else if (roll < 80) r.rule_caps = sparse_caps();
      end else begin
         r.op          = OP_EVAL;
         r.blocked     = ($urandom_range(0, 99) < 8);
         r.subj_domain = pick_domain();
         r.action_code = pick_action();
         if ($urandom_range(0, 99) < 85)
            r.score = TRUST_W'($urandom_range(0, 140) - 20);
         if ($urandom_range(0, 99) < 70)
            r.bias = TRUST_W'($urandom_range(0, 140) - 70);
         roll = $urandom_range(0, 99);
         if (roll < 30)      r.subj_caps = '1;
         else if (roll < 60) r.subj_caps = sparse_caps();
      end
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Sender: optional gap, present at the falling edge, hold until accepted.
   // Valid is only lowered when a gap follows, so a back-to-back request
   // never sees two assignments in the same step.
   // ------------------------------------------------------------------------
   task automatic send_request(input policy_request_type r);
      int gap;
      gap = send_idle ? $urandom_range(0, GAP_MAX) : 0;
      if (gap > 0) begin
         @(negedge clock) req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid           <= 1'b1;
      req_bus.action          <= r.op;
      req_bus.rule_any_domain <= r.any_domain;
      req_bus.rule_domain     <= r.rule_domain;
      req_bus.action_code     <= r.action_code;
      req_bus.rule_min_trust  <= r.trust_floor;
      req_bus.rule_caps       <= r.rule_caps;
      req_bus.subject_blocked <= r.blocked;
      req_bus.subject_domain  <= r.subj_domain;
      req_bus.subject_score   <= r.score;
      req_bus.subject_bias    <= r.bias;
      req_bus.subject_caps    <= r.subj_caps;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      decision_q.push_back(decide_policy(r));
   endtask

   // ------------------------------------------------------------------------
   // Receiver: check on the rising edge, pick ready on the falling edge.
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      policy_decision_type want;
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (decision_q.size() == 0) begin
               $error("unexpected response: verdict %0d matched %0d index %0d full %0d",
                      rsp_bus.verdict, rsp_bus.matched, rsp_bus.rule_index,
                      rsp_bus.table_full);
               error_count++;
            end else begin
               want = decision_q.pop_front();
               if (rsp_bus.verdict !== want.verdict) begin
                  $error("verdict: expected %0d, got %0d", want.verdict, rsp_bus.verdict);
                  error_count++;
               end
               if (rsp_bus.matched !== want.matched) begin
                  $error("matched: expected %0d, got %0d", want.matched, rsp_bus.matched);
                  error_count++;
               end
               if (rsp_bus.rule_index !== want.rule_index) begin
                  $error("rule_index: expected %0d, got %0d",
                         want.rule_index, rsp_bus.rule_index);
                  error_count++;
               end
               if (rsp_bus.table_full !== want.table_full) begin
                  $error("table_full: expected %0d, got %0d",
                         want.table_full, rsp_bus.table_full);
                  error_count++;
               end
            end
            stall_left = rsp_idle ? $urandom_range(0, GAP_MAX) : 0;
         end
         @(negedge clock);
         if (rsp_hold) begin
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Nothing loaded yet: every evaluate falls through to deny.
   task automatic test_empty_table();
      send_request(access_check_req(1'b0, 16'h0000, 8'h00, 16'sd0, 16'sd0, '0));
      send_request(access_check_req(1'b0, 16'hFFFF, 8'hFF, 16'sh7FFF, 16'sh7FFF, '1));
      send_request(access_check_req(1'b1, 16'h1234, 8'h01, 16'sd50, 16'sd0, '1));
   endtask

   // Hand-built rules with extreme fields, then probes of each outcome.
   task automatic test_directed_rules();
      // rule 0: plain rule, no threshold, no caps
      send_request(rule_append_req(1'b0, 16'h1234, 8'h01, 16'sd0, '0));
      // rule 1: any domain; the domain field must be ignored
      send_request(rule_append_req(1'b1, 16'hFFFF, 8'h02, 16'sd60, 32'h0000_00F0));
      // rule 2: top domain and action, highest minimum trust
      send_request(rule_append_req(1'b0, 16'hFFFF, 8'hFF, 16'sh7FFF, '0));
      // rule 3: bottom domain and action, lowest minimum, all caps needed
      send_request(rule_append_req(1'b0, 16'h0000, 8'h00, -16'sh8000, '1));
      // rule 4: shadowed by rule 0, never reachable
      send_request(rule_append_req(1'b0, 16'h1234, 8'h01, 16'sd100, 32'h1));
      // rule 5: any domain, action 3
      send_request(rule_append_req(1'b1, 16'h1234, 8'h03, 16'sd50, '0));

      // score exactly at the threshold passes, one below fails
      send_request(access_check_req(1'b0, 16'h1234, 8'h01, 16'sd0, 16'sd0, '0));
      send_request(access_check_req(1'b0, 16'h1234, 8'h01, -16'sd1, 16'sd0, '0));
      // wildcard rule: allow, missing one cap, one point short
      send_request(access_check_req(1'b0, 16'hBEEF, 8'h02, 16'sd60, 16'sd0, 32'h0000_00F0));
      send_request(access_check_req(1'b0, 16'hBEEF, 8'h02, 16'sd60, 16'sd0, 32'h0000_0070));
      send_request(access_check_req(1'b0, 16'hBEEF, 8'h02, 16'sd59, 16'sd0, 32'h0000_00F0));
      // huge positive bias clamps to +50, sum clamps to 100
      send_request(access_check_req(1'b0, 16'h0000, 8'h02, 16'sd100, 16'sh7FFF, '1));
      send_request(access_check_req(1'b0, 16'h0000, 8'h02, 16'sd99, 16'sh7FFF, '1));
      // huge negative bias clamps to -50; caps still missing
      send_request(access_check_req(1'b0, 16'h0000, 8'h02, 16'sd10, -16'sh8000, '0));
      // extreme minimum: need clamps to 100, extreme score both ways
      send_request(access_check_req(1'b0, 16'hFFFF, 8'hFF, 16'sh7FFF, 16'sd0, '0));
      send_request(access_check_req(1'b0, 16'hFFFF, 8'hFF, -16'sh8000, 16'sd50, '0));
      // lowest minimum: need clamps to 0, all caps vs one missing
      send_request(access_check_req(1'b0, 16'h0000, 8'h00, 16'sd0, -16'sd50, '1));
      send_request(access_check_req(1'b0, 16'h0000, 8'h00, 16'sd0, -16'sd50,
                                    32'hFFFF_FFFE));
      // blocked subject that would otherwise match
      send_request(access_check_req(1'b1, 16'h1234, 8'h01, 16'sd100, 16'sd0, '1));
      // just past the bias limit on the late wildcard rule
      send_request(access_check_req(1'b0, 16'h0000, 8'h03, 16'sd100, 16'sd51, '0));
      // no rule carries this action
      send_request(access_check_req(1'b0, 16'h1234, 8'h80, 16'sd100, 16'sd0, '1));
   endtask

   // Mixed traffic in segments; each segment picks its own idling on both
   // sides, and the second segment runs with none at all.
   task automatic run_random_traffic(input int total);
      for (int n = 0; n < total; n++) begin
         if (n % SEGMENT_LEN == 0) begin
            send_idle = (n == SEGMENT_LEN) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rsp_idle  = (n == SEGMENT_LEN) ? 1'b0 : ($urandom_range(0, 3) != 0);
         end
         send_request(random_request());
      end
      send_idle = 1'b1;
      rsp_idle  = 1'b1;
   endtask

   // Receiver goes quiet for a long stretch while requests keep coming
   // back to back, so the response slot fills and the input stalls.
   task automatic run_backpressure_burst();
      send_idle = 1'b0;
      fork
         begin
            rsp_hold = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_hold = 1'b0;
         end
      join_none
      for (int n = 0; n < PRESSURE_REQUESTS; n++)
         send_request(random_request());
      send_idle = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Run limit
   // ------------------------------------------------------------------------
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("policy_rule_first_match_unit test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      reset                   = 1'b1;
      req_bus.valid           = 1'b0;
      req_bus.action          = OP_ADD;
      req_bus.rule_any_domain = 1'b0;
      req_bus.rule_domain     = '0;
      req_bus.action_code     = '0;
      req_bus.rule_min_trust  = '0;
      req_bus.rule_caps       = '0;
      req_bus.subject_blocked = 1'b0;
      req_bus.subject_domain  = '0;
      req_bus.subject_score   = '0;
      req_bus.subject_bias    = '0;
      req_bus.subject_caps    = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      test_empty_table();
      test_directed_rules();
      run_random_traffic(RANDOM_REQUESTS);
      run_backpressure_burst();
      @(negedge clock) req_bus.valid <= 1'b0;

      // wait out outstanding responses, then watch for strays
      while (decision_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && decision_q.size() == 0)
         $display("policy_rule_first_match_unit test passed");
      else
         $display("policy_rule_first_match_unit test failed");
      $finish;
   end

endmodule

`default_nettype wire
